@@ rtl/core/bco_pkg.sv @@
// shared types and constants for the breakpoint code overlay
// no dependencies; used by bco_ifs, bco_bp_table and breakpoint_code_overlay
package bco_pkg;

    localparam int NUM_BREAKPOINTS = 16;
    localparam int OVERLAY_DEPTH   = 256;
    localparam int OVL_ADDR_W      = $clog2(OVERLAY_DEPTH);
    localparam int ADDR_W          = 16;
    localparam int BYTE_W          = 8;
    localparam int SLOT_W          = 4;
    localparam int REQ_W           = 3;

    localparam logic [ADDR_W-1:0] PAGE_MASK = 16'hff00;

    typedef enum logic [REQ_W-1:0] {
        REQ_CPU_READ  = 3'd0,
        REQ_CPU_WRITE = 3'd1,
        REQ_POKE_CODE = 3'd2,
        REQ_POKE_DATA = 3'd3,
        REQ_PEEK_DATA = 3'd4,
        REQ_SET_BP    = 3'd5,
        REQ_CLR_BP    = 3'd6
    } req_kind_t;

    // which store feeds read_data of a pending result
    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_CODE,
        SRC_DATA
    } rd_src_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } fsm_state_t;

    typedef struct packed {
        logic              set_en;
        logic              clr_en;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] set_addr;
    } bp_cmd_t;

    typedef struct packed {
        logic              match;
        logic [SLOT_W-1:0] slot;
    } bp_match_t;

endpackage

@@ rtl/core/bco_ifs.sv @@
// valid/ready channel interfaces for requests and responses
// depends on bco_pkg for field widths
interface bco_req_if;
    logic                          valid;
    logic                          ready;
    logic [bco_pkg::REQ_W-1:0]     req_type;
    logic [bco_pkg::ADDR_W-1:0]    addr;
    logic [bco_pkg::BYTE_W-1:0]    data;
    logic [bco_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, req_type, addr, data, slot, input ready);
    modport sink   (input valid, req_type, addr, data, slot, output ready);
endinterface

interface bco_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [bco_pkg::BYTE_W-1:0]    read_data;
    logic                          resumed;

    modport source (output valid, hit, read_data, resumed, input ready);
    modport sink   (input valid, hit, read_data, resumed, output ready);
endinterface

@@ rtl/core/bco_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/bco_bp_table.sv @@
// breakpoint address table with active mask and parallel lowest-slot match
// depends on bco_pkg
module bco_bp_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bco_pkg::bp_cmd_t             cmd,
    input  logic [bco_pkg::ADDR_W-1:0]   query,
    output bco_pkg::bp_match_t           result
);

    import bco_pkg::*;

    logic [ADDR_W-1:0]          bp_addr_reg [NUM_BREAKPOINTS];
    logic [NUM_BREAKPOINTS-1:0] active_reg;
    logic [NUM_BREAKPOINTS-1:0] active_next;

    always_comb
    begin
        active_next = active_reg;
        for (int i = 0; i < NUM_BREAKPOINTS; i++)
        begin
            if (cmd.slot == SLOT_W'(i))
            begin
                if (cmd.set_en)
                begin
                    active_next[i] = 1'b1;
                end
                else if (cmd.clr_en)
                begin
                    active_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // addresses are only compared once their slot has been set
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_BREAKPOINTS; i++)
        begin
            if (cmd.set_en && cmd.slot == SLOT_W'(i))
            begin
                bp_addr_reg[i] <= cmd.set_addr;
            end
        end
    end

    // scan from the top so the lowest matching slot wins
    always_comb
    begin
        result = '0;
        for (int i = NUM_BREAKPOINTS - 1; i >= 0; i--)
        begin
            if (active_reg[i] && bp_addr_reg[i] == query)
            begin
                result.match = 1'b1;
                result.slot  = SLOT_W'(i);
            end
        end
    end

endmodule

@@ rtl/core/breakpoint_code_overlay.sv @@
// top level of the breakpoint code overlay: control sequencer, code and data stores
// depends on bco_pkg, bco_ifs, bco_ram, bco_bp_table
//
//   channel | dir | carries
//   --------+-----+----------------------------------------
//   req     | in  | req_type, addr, data, slot
//   rsp     | out | hit, read_data, resumed (one per request)
//
// in the accept cycle of a request the store read or write is issued and
// breakpoint state is updated; the read-back state then takes the registered
// ram output. after reset a clearing pass zeroes all 256 entries of both stores;
// req.ready is low during it. a stalled response holds in the output register and
// the next request is still accepted; only the read-back cycle waits on rsp.ready.
module breakpoint_code_overlay (
    input  logic       clk,
    input  logic       rst_n,
    bco_req_if.sink    req,
    bco_rsp_if.source  rsp
);

    import bco_pkg::*;

    fsm_state_t              state_reg, state_next;
    logic [OVL_ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;

    logic                    stopped_reg, stopped_next;
    logic [ADDR_W-1:0]       base_reg, base_next;
    logic [SLOT_W-1:0]       hit_slot_reg, hit_slot_next;

    logic                    pend_hit_reg, pend_hit_next;
    logic                    pend_res_reg, pend_res_next;
    rd_src_t                 pend_src_reg, pend_src_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_hit_reg, out_hit_next;
    logic [BYTE_W-1:0]       out_data_reg, out_data_next;
    logic                    out_res_reg, out_res_next;

    logic                    accept;
    logic                    clearing;
    logic                    load;
    req_kind_t               kind;
    logic [OVL_ADDR_W-1:0]   a_byte;
    logic [ADDR_W-1:0]       rel_addr;

    logic                    code_we, data_we, code_req_we, data_req_we;
    logic [OVL_ADDR_W-1:0]   code_waddr, data_waddr, code_raddr;
    logic [BYTE_W-1:0]       code_wdata, data_wdata, code_q, data_q;
    bp_cmd_t                 bp_cmd;
    bp_match_t               bp_res;
    logic                    slot_ok;

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == OVL_ADDR_W'(OVERLAY_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready = 1'b0;
        clearing  = 1'b0;
        load      = 1'b0;
        unique case (state_reg)
            ST_CLEAR: clearing  = 1'b1;
            ST_IDLE:  req.ready = 1'b1;
            ST_READ:  load      = !out_valid_reg || rsp.ready;
            default:  clearing  = 1'b0;
        endcase
    end

    assign accept   = req.valid && req.ready;
    assign kind     = req_kind_t'(req.req_type);
    assign a_byte   = req.addr[OVL_ADDR_W-1:0];
    assign rel_addr = req.addr - base_reg;
    assign slot_ok  = {1'b0, req.slot} < (SLOT_W + 1)'(NUM_BREAKPOINTS);

    // request decode: store access, breakpoint update, pending result
    always_comb
    begin
        stopped_next  = stopped_reg;
        base_next     = base_reg;
        hit_slot_next = hit_slot_reg;
        pend_hit_next = pend_hit_reg;
        pend_res_next = pend_res_reg;
        pend_src_next = pend_src_reg;
        code_req_we   = 1'b0;
        data_req_we   = 1'b0;
        // a breakpoint hit supplies code byte 0
        code_raddr    = stopped_reg ? rel_addr[OVL_ADDR_W-1:0] : '0;
        bp_cmd        = '0;
        bp_cmd.slot   = req.slot;
        bp_cmd.set_addr = req.addr;

        if (accept)
        begin
            pend_hit_next = 1'b0;
            pend_res_next = 1'b0;
            pend_src_next = SRC_NONE;
            case (kind)
                REQ_CPU_READ:
                begin
                    if (!stopped_reg)
                    begin
                        if (bp_res.match)
                        begin
                            stopped_next  = 1'b1;
                            base_next     = req.addr;
                            hit_slot_next = bp_res.slot;
                            pend_hit_next = 1'b1;
                            pend_src_next = SRC_CODE;
                        end
                    end
                    else if (req.addr == base_reg)
                    begin
                        // resume: drop the breakpoint that stopped us
                        stopped_next  = 1'b0;
                        bp_cmd.clr_en = 1'b1;
                        bp_cmd.slot   = hit_slot_reg;
                        pend_res_next = 1'b1;
                    end
                    else
                    begin
                        pend_hit_next = 1'b1;
                        pend_src_next = ((req.addr & PAGE_MASK) == PAGE_MASK) ?
                                        SRC_DATA : SRC_CODE;
                    end
                end
                REQ_CPU_WRITE:
                begin
                    if (stopped_reg)
                    begin
                        data_req_we   = 1'b1;
                        pend_hit_next = 1'b1;
                    end
                end
                REQ_POKE_CODE:
                begin
                    code_req_we = 1'b1;
                end
                REQ_POKE_DATA:
                begin
                    data_req_we = 1'b1;
                end
                REQ_PEEK_DATA:
                begin
                    pend_hit_next = 1'b1;
                    pend_src_next = SRC_DATA;
                end
                REQ_SET_BP:
                begin
                    bp_cmd.set_en = slot_ok;
                end
                REQ_CLR_BP:
                begin
                    bp_cmd.clr_en = slot_ok;
                end
                default:
                begin
                    pend_src_next = SRC_NONE;
                end
            endcase
        end
    end

    // clearing pass shares the write ports
    assign code_we    = clearing || code_req_we;
    assign data_we    = clearing || data_req_we;
    assign code_waddr = clearing ? clr_cnt_reg : a_byte;
    assign data_waddr = clearing ? clr_cnt_reg : a_byte;
    assign code_wdata = clearing ? '0 : req.data;
    assign data_wdata = clearing ? '0 : req.data;

    // response register
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_data_next  = out_data_reg;
        out_res_next   = out_res_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_hit_next   = pend_hit_reg;
            out_res_next   = pend_res_reg;
            case (pend_src_reg)
                SRC_CODE: out_data_next = code_q;
                SRC_DATA: out_data_next = data_q;
                default:  out_data_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            stopped_reg   <= 1'b0;
            base_reg      <= '0;
            hit_slot_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            stopped_reg   <= stopped_next;
            base_reg      <= base_next;
            hit_slot_reg  <= hit_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_hit_reg <= pend_hit_next;
        pend_res_reg <= pend_res_next;
        pend_src_reg <= pend_src_next;
        out_hit_reg  <= out_hit_next;
        out_data_reg <= out_data_next;
        out_res_reg  <= out_res_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.resumed   = out_res_reg;

    bco_bp_table u_bp_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (bp_cmd),
        .query  (req.addr),
        .result (bp_res)
    );

    bco_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (OVERLAY_DEPTH)
    ) u_code_ram (
        .clk   (clk),
        .we    (code_we),
        .waddr (code_waddr),
        .wdata (code_wdata),
        .re    (accept),
        .raddr (code_raddr),
        .rdata (code_q)
    );

    bco_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (OVERLAY_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (accept),
        .raddr (a_byte),
        .rdata (data_q)
    );

endmodule
